// ===== rtl/emrd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emrd_pkg
// Shared widths, constants and side-band types of the midpoint displacement
// core.
// ----------------------------------------------------------------------------
package emrd_pkg;

   // field widths
   localparam int CoordW  = 32;
   localparam int JitW    = 6;
   localparam int GenW    = 4;
   localparam int Lanes   = 3;

   // length unit: 64-bit sum of squares in, 32-bit root out
   localparam int SqW     = 2 * CoordW;
   localparam int RootW   = SqW / 2;

   // scale unit: quotient bits below the saturation limit
   localparam int QuotW   = CoordW - 1;

   // register reset and arithmetic constants
   localparam logic [GenW-1:0]   GEN_RESET = GenW'(1);
   localparam logic [4:0]        DISP_BASE = 5'd17;
   localparam logic [JitW:0]     JIT_BIAS  = 7'd32;
   localparam logic [CoordW-1:0] SAT_POS   = 32'h7FFF_FFFF;
   localparam logic [CoordW-1:0] SAT_NEG   = 32'h8000_0000;

   // side data carried beside the length unit
   typedef struct packed {
      logic [Lanes-1:0]             msign;
      logic [Lanes-1:0][CoordW-1:0] mmag;
      logic [JitW-1:0]              jitter;
   } len_side_type;

   // side data carried beside the divider
   typedef struct packed {
      logic [Lanes-1:0] neg;
      logic [Lanes-1:0] sat;
      logic             degenerate;
   } div_side_type;

endpackage
`default_nettype wire

// ===== rtl/emrd_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emrd_req_if
// Request channel: one edge with both endpoints and a 6-bit jitter value.
// ----------------------------------------------------------------------------
interface emrd_req_if;
   import emrd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] ax;
   logic signed [CoordW-1:0] ay;
   logic signed [CoordW-1:0] az;
   logic signed [CoordW-1:0] bx;
   logic signed [CoordW-1:0] by;
   logic signed [CoordW-1:0] bz;
   logic        [JitW-1:0]   jitter;

   modport source (output valid, ax, ay, az, bx, by, bz, jitter, input ready);
   modport sink   (input valid, ax, ay, az, bx, by, bz, jitter, output ready);
endinterface
`default_nettype wire

// ===== rtl/emrd_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emrd_rsp_if
// Result channel: displaced midpoint and the zero-length flag.
// ----------------------------------------------------------------------------
interface emrd_rsp_if;
   import emrd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] mx;
   logic signed [CoordW-1:0] my;
   logic signed [CoordW-1:0] mz;
   logic                     degenerate;

   modport source (output valid, mx, my, mz, degenerate, input ready);
   modport sink   (input valid, mx, my, mz, degenerate, output ready);
endinterface
`default_nettype wire

// ===== rtl/emrd_isqrt_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emrd_isqrt_pipe
// Multi-lane pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module emrd_isqrt_pipe #(
   parameter int N  = 3,
   parameter int VW = 64,
   parameter int SW = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [N-1:0][VW-1:0]  in_val,
   input  wire logic [SW-1:0]         in_side,
   output logic                       out_valid,
   output logic [N-1:0][VW/2-1:0]     out_root,
   output logic [SW-1:0]              out_side
);
   localparam int RW = VW / 2;

   logic [N-1:0][RW+1:0] rem_ff  [RW];
   logic [N-1:0][RW-1:0] root_ff [RW];
   logic [N-1:0][VW-1:0] val_ff  [RW];
   logic [SW-1:0]        side_ff [RW];
   logic [RW-1:0]        vld_ff;

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [N-1:0][RW+1:0] rem_src, rem_in;
      logic [N-1:0][RW-1:0] root_src, root_in;
      logic [N-1:0][VW-1:0] val_src, val_in;
      logic [SW-1:0]        side_src;
      logic                 vld_src;

      // stage source: ports for the first stage, previous stage otherwise
      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign val_src  = in_val;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign val_src  = val_ff[k-1];
         assign side_src = side_ff[k-1];
         assign vld_src  = vld_ff[k-1];
      end

      // bring in two radicand bits, try the next root bit
      always_comb begin
         logic [RW+3:0] sh;
         logic [RW+3:0] tr;
         for (int i = 0; i < N; i++) begin
            sh = {rem_src[i], val_src[i][VW-1 -: 2]};
            tr = {2'b00, root_src[i], 2'b01};
            if (sh >= tr) begin
               rem_in[i]  = (RW+2)'(sh - tr);
               root_in[i] = {root_src[i][RW-2:0], 1'b1};
            end else begin
               rem_in[i]  = sh[RW+1:0];
               root_in[i] = {root_src[i][RW-2:0], 1'b0};
            end
            val_in[i] = {val_src[i][VW-3:0], 2'b00};
         end
      end

      // stage register
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            val_ff[k]  <= val_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];
endmodule
`default_nettype wire

// ===== rtl/emrd_div_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emrd_div_pipe
// Multi-lane pipelined restoring divider with a shared divisor, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module emrd_div_pipe #(
   parameter int N  = 3,
   parameter int DW = 64,
   parameter int NW = 32,
   parameter int QW = 31,
   parameter int SW = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [N-1:0][DW-1:0]  in_num,
   input  wire logic [NW-1:0]         in_den,
   input  wire logic [SW-1:0]         in_side,
   output logic                       out_valid,
   output logic [N-1:0][QW-1:0]       out_quot,
   output logic [SW-1:0]              out_side
);
   logic [N-1:0][DW-1:0] rem_ff  [QW];
   logic [N-1:0][QW-1:0] quot_ff [QW];
   logic [NW-1:0]        den_ff  [QW];
   logic [SW-1:0]        side_ff [QW];
   logic [QW-1:0]        vld_ff;

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int Shift = QW - 1 - k;

      logic [N-1:0][DW-1:0] rem_src, rem_in;
      logic [N-1:0][QW-1:0] quot_src, quot_in;
      logic [NW-1:0]        den_src;
      logic [SW-1:0]        side_src;
      logic                 vld_src;
      logic [DW-1:0]        dsh;

      if (k == 0) begin : g_first
         assign rem_src  = in_num;
         assign quot_src = '0;
         assign den_src  = in_den;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign quot_src = quot_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign side_src = side_ff[k-1];
         assign vld_src  = vld_ff[k-1];
      end

      // divisor aligned to this quotient bit
      assign dsh = DW'({{(DW-NW){1'b0}}, den_src} << Shift);

      // compare and subtract per lane
      always_comb begin
         for (int i = 0; i < N; i++) begin
            if (rem_src[i] >= dsh) begin
               rem_in[i]  = rem_src[i] - dsh;
               quot_in[i] = {quot_src[i][QW-2:0], 1'b1};
            end else begin
               rem_in[i]  = rem_src[i];
               quot_in[i] = {quot_src[i][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            quot_ff[k] <= quot_in;
            den_ff[k]  <= den_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
   assign out_side  = side_ff[QW-1];
endmodule
`default_nettype wire

// ===== rtl/edge_midpoint_radial_displace_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request per cycle while rsp is not stalled; five front stages,
// a 32-stage root unit, four scale stages, a 31-stage divider and the output register.
// The whole pipe advances together; it holds while a result waits on rsp.
// Reset (synchronous, active high) clears all valid bits and sets
// generation to 1.
// ----------------------------------------------------------------------------
// edge_midpoint_radial_displace_core
// Displaced midpoint vertex of one subdivided edge, fixed-point Q16.16.
// ----------------------------------------------------------------------------
module edge_midpoint_radial_displace_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   emrd_req_if.sink                   req,
   emrd_rsp_if.source                 rsp,
   input  wire logic                  csr_wr_en,
   input  wire logic [emrd_pkg::GenW-1:0] csr_wr_data
);
   import emrd_pkg::*;

   logic en;

   // configuration register
   logic [GenW-1:0] gen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= GEN_RESET;
      end else if (csr_wr_en) begin
         gen_ff <= csr_wr_data;
      end
   end

   // global advance: output register empty or being drained
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // stage 1: request capture
   logic                                v1_ff;
   logic signed [Lanes-1:0][CoordW-1:0] a1_ff, b1_ff;
   logic        [JitW-1:0]              jit1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff   <= {req.az, req.ay, req.ax};
         b1_ff   <= {req.bz, req.by, req.bx};
         jit1_ff <= req.jitter;
      end
   end

   // stage 2: endpoint magnitudes and floored midpoint
   logic                         v2_ff;
   logic [Lanes-1:0][CoordW-1:0] amag2_ff, bmag2_ff, m2_ff;
   logic [JitW-1:0]              jit2_ff;
   logic [Lanes-1:0][CoordW-1:0] amag2_in, bmag2_in, m2_in;

   always_comb begin
      logic [CoordW:0] s;
      for (int i = 0; i < Lanes; i++) begin
         amag2_in[i] = a1_ff[i][CoordW-1] ? CoordW'(-a1_ff[i]) : a1_ff[i];
         bmag2_in[i] = b1_ff[i][CoordW-1] ? CoordW'(-b1_ff[i]) : b1_ff[i];
         s           = {a1_ff[i][CoordW-1], a1_ff[i]} + {b1_ff[i][CoordW-1], b1_ff[i]};
         m2_in[i]    = s[CoordW:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         amag2_ff <= amag2_in;
         bmag2_ff <= bmag2_in;
         m2_ff    <= m2_in;
         jit2_ff  <= jit1_ff;
      end
   end

   // stage 3: midpoint magnitude and sign
   logic                         v3_ff;
   logic [Lanes-1:0][CoordW-1:0] amag3_ff, bmag3_ff, mmag3_ff, mmag3_in;
   logic [Lanes-1:0]             msign3_ff, msign3_in;
   logic [JitW-1:0]              jit3_ff;

   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         msign3_in[i] = m2_ff[i][CoordW-1];
         mmag3_in[i]  = m2_ff[i][CoordW-1] ? CoordW'(-m2_ff[i]) : m2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         amag3_ff  <= amag2_ff;
         bmag3_ff  <= bmag2_ff;
         mmag3_ff  <= mmag3_in;
         msign3_ff <= msign3_in;
         jit3_ff   <= jit2_ff;
      end
   end

   // stage 4: squares
   logic                         v4_ff;
   logic [Lanes-1:0][SqW-1:0]    asq4_ff, bsq4_ff, msq4_ff;
   logic [Lanes-1:0][CoordW-1:0] mmag4_ff;
   logic [Lanes-1:0]             msign4_ff;
   logic [JitW-1:0]              jit4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < Lanes; i++) begin
            asq4_ff[i] <= amag3_ff[i] * amag3_ff[i];
            bsq4_ff[i] <= bmag3_ff[i] * bmag3_ff[i];
            msq4_ff[i] <= mmag3_ff[i] * mmag3_ff[i];
         end
         mmag4_ff  <= mmag3_ff;
         msign4_ff <= msign3_ff;
         jit4_ff   <= jit3_ff;
      end
   end

   // stage 5: sums of squares, lane 0 a, lane 1 b, lane 2 midpoint
   logic                      v5_ff;
   logic [Lanes-1:0][SqW-1:0] sum5_ff;
   len_side_type              lside5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum5_ff[0]       <= asq4_ff[0] + asq4_ff[1] + asq4_ff[2];
         sum5_ff[1]       <= bsq4_ff[0] + bsq4_ff[1] + bsq4_ff[2];
         sum5_ff[2]       <= msq4_ff[0] + msq4_ff[1] + msq4_ff[2];
         lside5_ff.msign  <= msign4_ff;
         lside5_ff.mmag   <= mmag4_ff;
         lside5_ff.jitter <= jit4_ff;
      end
   end

   // lengths of both endpoints and of the midpoint
   logic                        vq_w;
   logic [Lanes-1:0][RootW-1:0] root_w;
   len_side_type                lside_w;

   emrd_isqrt_pipe #(
      .N  (Lanes),
      .VW (SqW),
      .SW ($bits(len_side_type))
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_val    (sum5_ff),
      .in_side   (lside5_ff),
      .out_valid (vq_w),
      .out_root  (root_w),
      .out_side  (lside_w)
   );

   // stage 6: target radius
   logic                         v6_ff;
   logic signed [CoordW+2:0]     r6_ff, r6_in;
   logic [RootW-1:0]             n6_ff;
   logic                         deg6_ff;
   logic [Lanes-1:0][CoordW-1:0] mmag6_ff;
   logic [Lanes-1:0]             msign6_ff;

   always_comb begin
      logic [RootW:0]           rsum;
      logic signed [JitW:0]     jit_s;
      logic [4:0]               shamt;
      logic signed [CoordW+2:0] disp;
      rsum  = {1'b0, root_w[0]} + {1'b0, root_w[1]};
      jit_s = $signed({1'b0, lside_w.jitter} - JIT_BIAS);
      shamt = DISP_BASE - {1'b0, gen_ff};
      disp  = (CoordW+3)'(jit_s) <<< shamt;
      r6_in = $signed({2'b00, rsum[RootW:1]}) + disp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= vq_w;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r6_ff     <= r6_in;
         n6_ff     <= root_w[2];
         deg6_ff   <= (root_w[2] == '0);
         mmag6_ff  <= lside_w.mmag;
         msign6_ff <= lside_w.msign;
      end
   end

   // stage 7: radius magnitude and result signs
   logic                         v7_ff;
   logic [CoordW:0]              rmag7_ff;
   logic [RootW-1:0]             n7_ff;
   logic                         deg7_ff;
   logic [Lanes-1:0][CoordW-1:0] mmag7_ff;
   logic [Lanes-1:0]             neg7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rmag7_ff <= r6_ff[CoordW+2] ? (CoordW+1)'(-r6_ff) : r6_ff[CoordW:0];
         for (int i = 0; i < Lanes; i++) begin
            neg7_ff[i] <= msign6_ff[i] ^ r6_ff[CoordW+2];
         end
         n7_ff    <= n6_ff;
         deg7_ff  <= deg6_ff;
         mmag7_ff <= mmag6_ff;
      end
   end

   // stage 8: products |m| * |r|
   logic                           v8_ff;
   logic [Lanes-1:0][2*CoordW:0]   prod8_ff;
   logic [RootW-1:0]               n8_ff;
   logic                           deg8_ff;
   logic [Lanes-1:0]               neg8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < Lanes; i++) begin
            prod8_ff[i] <= {1'b0, mmag7_ff[i]} * rmag7_ff;
         end
         n8_ff   <= n7_ff;
         deg8_ff <= deg7_ff;
         neg8_ff <= neg7_ff;
      end
   end

   // stage 9: saturation check, quotient would reach 2^31
   logic                      v9_ff;
   logic [Lanes-1:0][SqW-1:0] num9_ff;
   logic [RootW-1:0]          n9_ff;
   div_side_type              dside9_ff;
   logic [Lanes-1:0]          sat9_in;
   logic [2*CoordW:0]         lim9;

   assign lim9 = (2*CoordW+1)'({n8_ff, {QuotW{1'b0}}});

   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         sat9_in[i] = (prod8_ff[i] >= lim9);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (en) begin
         v9_ff <= v8_ff;
      end
   end

   // product stays below 2^64 since |m| <= 2^31 and |r| < 2^33
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < Lanes; i++) begin
            num9_ff[i] <= prod8_ff[i][SqW-1:0];
         end
         n9_ff                <= n8_ff;
         dside9_ff.neg        <= neg8_ff;
         dside9_ff.sat        <= sat9_in;
         dside9_ff.degenerate <= deg8_ff;
      end
   end

   // scale by 1/n
   logic                        vd_w;
   logic [Lanes-1:0][QuotW-1:0] quot_w;
   div_side_type                dside_w;

   emrd_div_pipe #(
      .N  (Lanes),
      .DW (SqW),
      .NW (RootW),
      .QW (QuotW),
      .SW ($bits(div_side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v9_ff),
      .in_num    (num9_ff),
      .in_den    (n9_ff),
      .in_side   (dside9_ff),
      .out_valid (vd_w),
      .out_quot  (quot_w),
      .out_side  (dside_w)
   );

   // output register: sign, saturation and zero-length override
   logic [Lanes-1:0][CoordW-1:0] res_ff, res_in;
   logic                         deg_ff;

   always_comb begin
      logic [CoordW-1:0] q;
      for (int i = 0; i < Lanes; i++) begin
         q = {1'b0, quot_w[i]};
         if (dside_w.degenerate) begin
            res_in[i] = '0;
         end else if (dside_w.sat[i]) begin
            res_in[i] = dside_w.neg[i] ? SAT_NEG : SAT_POS;
         end else if (dside_w.neg[i]) begin
            res_in[i] = CoordW'(-q);
         end else begin
            res_in[i] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vd_w;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         deg_ff <= dside_w.degenerate;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.mx         = res_ff[0];
   assign rsp.my         = res_ff[1];
   assign rsp.mz         = res_ff[2];
   assign rsp.degenerate = deg_ff;

   // a zero-length midpoint always gives the zero vector
   a_deg_zero : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.degenerate |-> rsp.mx == 0 && rsp.my == 0 && rsp.mz == 0)
      else $error("degenerate result with nonzero coordinates");

   // reset empties the pipe
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp.valid && !v1_ff && !v9_ff)
      else $error("valid bits survive reset");

   // a stall freezes the pipe's occupancy
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v1_ff) && $stable(v5_ff) && $stable(v9_ff) && $stable(vd_w))
      else $error("pipe moved during stall");

endmodule
`default_nettype wire

// ===== tb/tb_emrd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_emrd_if
// Testbench-side note: the request and result channel interfaces come from
// the RTL (emrd_req_if, emrd_rsp_if); this file only groups a helper type.
// ----------------------------------------------------------------------------
package tb_emrd_types;
   import emrd_pkg::*;

   // one expected displaced vertex
   typedef struct {
      logic signed [CoordW-1:0] mx;
      logic signed [CoordW-1:0] my;
      logic signed [CoordW-1:0] mz;
      logic                     degenerate;
   } vertex_type;
endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the midpoint displacement core: edges go in on the request channel,
// a local fixed-point predictor computes each displaced vertex, and every
// result is compared in order, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
   import emrd_pkg::*;
   import tb_emrd_types::*;

   localparam int WatchLimit = 20000;
   localparam int DrainWait  = 200;

   // scoreboard of predicted vertices
   class vertex_board;
      vertex_type pending[$];
      int         errors;
      int         matched;
      logic [GenW-1:0] gen;

      function new();
         errors = 0;
         matched = 0;
         gen = GEN_RESET;
      endfunction

      static function logic [63:0] root64(logic [63:0] v);
         logic [63:0] res;
         logic [63:0] b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      static function logic [63:0] absval(longint v);
         return (v < 0) ? 64'(-v) : 64'(v);
      endfunction

      static function logic [63:0] length3(longint x, longint y, longint z);
         logic [63:0] ux, uy, uz;
         ux = absval(x);
         uy = absval(y);
         uz = absval(z);
         return root64(ux * ux + uy * uy + uz * uz);
      endfunction

      static function longint halve(longint s);
         return s >>> 1;
      endfunction

      static function logic [31:0] scale_clip(longint m, longint r, logic [63:0] n);
         logic [63:0] q;
         logic        neg;
         q = (absval(m) * absval(r)) / n;
         neg = (m < 0) != (r < 0);
         if (q == 0) return 32'd0;
         if (neg) return (q >= 64'h8000_0000) ? SAT_NEG : 32'(-q);
         return (q > 64'h7FFF_FFFF) ? SAT_POS : 32'(q);
      endfunction

      // note an accepted edge
      function void note_edge(logic signed [31:0] ax, ay, az, bx, by, bz,
                              logic [JitW-1:0] jit);
         vertex_type  v;
         logic [63:0] ra, rb, n;
         longint      mean, disp, r, mx, my, mz;
         ra = length3(ax, ay, az);
         rb = length3(bx, by, bz);
         mean = longint'((ra + rb) >> 1);
         disp = (longint'(jit) - 32) * (longint'(1) << (17 - int'(gen)));
         r = mean + disp;
         mx = halve(longint'(ax) + longint'(bx));
         my = halve(longint'(ay) + longint'(by));
         mz = halve(longint'(az) + longint'(bz));
         n = length3(mx, my, mz);
         if (n == 0) begin
            v.mx = 0; v.my = 0; v.mz = 0; v.degenerate = 1'b1;
         end else begin
            v.mx = scale_clip(mx, r, n);
            v.my = scale_clip(my, r, n);
            v.mz = scale_clip(mz, r, n);
            v.degenerate = 1'b0;
         end
         pending.insert(pending.size(), v);
      endfunction

      // compare one result with the oldest prediction
      function void check_vertex(logic signed [31:0] mx, my, mz, logic dg);
         vertex_type e;
         if (pending.size() == 0) begin
            $error("unexpected result mx=%0d", mx);
            errors++;
            return;
         end
         e = pending.pop_front();
         matched++;
         if (mx !== e.mx) begin $error("mx exp %0d got %0d", e.mx, mx); errors++; end
         if (my !== e.my) begin $error("my exp %0d got %0d", e.my, my); errors++; end
         if (mz !== e.mz) begin $error("mz exp %0d got %0d", e.mz, mz); errors++; end
         if (dg !== e.degenerate) begin
            $error("degenerate exp %0b got %0b", e.degenerate, dg);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [GenW-1:0] csr_wr_data;
   emrd_req_if req ();
   emrd_rsp_if rsp ();
   vertex_board board;
   int  idle_cycles;
   bit  hold_rsp;
   bit  sending_done;

   edge_midpoint_radial_displace_core dut (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      board = new();
      req.valid = 1'b0;
      {req.ax, req.ay, req.az, req.bx, req.by, req.bz} = '0;
      req.jitter = '0;
      rsp.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      hold_rsp = 1'b0;
      sending_done = 1'b0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // random coordinate: mostly moderate values, sometimes extremes
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(0, 3)) - 32'd1;
         3, 4: return $urandom();
         default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      endcase
   endfunction

   // offer one edge and wait for its acceptance
   task automatic send_edge(logic [31:0] ax, ay, az, bx, by, bz, logic [5:0] jit);
      int gap;
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) gap = 0;
      // valid stays high across back-to-back requests
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.ax <= ax; req.ay <= ay; req.az <= az;
      req.bx <= bx; req.by <= by; req.bz <= bz;
      req.jitter <= jit;
      do @(posedge clock); while (!req.ready);
      board.note_edge(ax, ay, az, bx, by, bz, jit);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   // write the generation register while idle
   task automatic write_generation(logic [GenW-1:0] g);
      csr_wr_en <= 1'b1;
      csr_wr_data <= g;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.gen = g;
   endtask

   task automatic random_edges(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_edge(pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_coord(), pick_coord(), 6'($urandom_range(0, 63)));
         else begin
            logic [31:0] x, y, z;
            x = pick_coord(); y = pick_coord(); z = pick_coord();
            // nearby endpoints, as in a real mesh edge
            send_edge(x, y, z, x + $urandom_range(0, 4095), y - $urandom_range(0, 4095),
                      z + $urandom_range(0, 4095), 6'($urandom_range(0, 63)));
         end
      end
   endtask

   // stimulus
   initial begin
      logic [GenW-1:0] gens[6];
      gens = '{4'd0, 4'd15, 4'd3, 4'd8, 4'd1, 4'd12};
      @(negedge reset);
      @(posedge clock);
      // directed edges at reset generation
      send_edge(0, 0, 0, 0, 0, 0, 6'd32);
      send_edge(32'h10000, 0, 0, 32'hFFFF0000, 0, 0, 6'd0);
      send_edge(32'h10000, 0, 0, 0, 32'h10000, 0, 6'd63);
      send_edge(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd63);
      send_edge(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 6'd0);
      send_edge(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF,
                32'hFFFF_FFFF, 6'd17);
      send_edge(32'h20000, 32'h20000, 0, 32'h20000, 32'h20000, 0, 6'd0);
      send_edge(32'hFFFFFFFF, 0, 0, 32'h0, 0, 0, 6'd45);
      send_edge(32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 6'd0);
      send_edge(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 6'd42);
      random_edges(40);
      // pause until everything is out
      wait_drained();
      // long receiver hold so the pipe fills and stalls its input
      hold_rsp = 1'b1;
      random_edges(100);
      hold_rsp = 1'b0;
      foreach (gens[k]) begin
         wait_drained();
         write_generation(gens[k]);
         send_edge(32'h10000, 0, 0, 32'h10000, 0, 0, 6'd0);
         send_edge(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0, 6'd63);
         random_edges(80);
      end
      req.valid <= 1'b0;
      sending_done = 1'b1;
   end

   // receiver: random stalls, plus one long hold while the sender keeps going
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            stall = 0;
            while (stall < 300) begin
               @(posedge clock);
               stall++;
            end
            while (hold_rsp && stall < 2000) begin
               @(posedge clock);
               stall++;
            end
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if (stall != 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         board.check_vertex(rsp.mx, rsp.my, rsp.mz, rsp.degenerate);
      end
   end

   // watchdog and final verdict
   initial begin
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (sending_done && board.pending.size() == 0) begin
            repeat (DrainWait) @(posedge clock);
            $display("covered %0d edges over seven generation settings, with hold-offs",
                     board.matched);
            if (board.errors == 0 && board.pending.size() == 0)
               $display("simulation ok");
            else
               $display("simulation failed");
            $finish;
         end
         if (idle_cycles >= WatchLimit) begin
            $display("timeout with %0d results pending", board.pending.size());
            $display("simulation failed");
            $finish;
         end
      end
   end
endmodule

// ===== edge_midpoint_radial_displace_core.f =====
rtl/emrd_pkg.sv
rtl/emrd_req_if.sv
rtl/emrd_rsp_if.sv
rtl/emrd_isqrt_pipe.sv
rtl/emrd_div_pipe.sv
rtl/edge_midpoint_radial_displace_core.sv
tb/tb_emrd_if.sv
tb/tb.sv
